### src/ssw_pkg.sv
// Shared types, constants and helpers for the slotted stop-and-wait link.
`default_nettype none
package ssw_pkg;

  localparam int unsigned TICK_W   = 8;
  localparam int unsigned RETRY_W  = 4;
  localparam int unsigned TYPE_W   = 4;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned KIND_W   = 2;

  localparam int unsigned SQ_DEPTH = 8;
  localparam int unsigned SQ_PTR_W = $clog2(SQ_DEPTH);
  localparam int unsigned SQ_CNT_W = $clog2(SQ_DEPTH + 1);
  localparam int unsigned SQ_SUM_W = SQ_CNT_W + 1;

  localparam int unsigned AQ_DEPTH = 8;
  localparam int unsigned AQ_PTR_W = $clog2(AQ_DEPTH);
  localparam int unsigned AQ_CNT_W = $clog2(AQ_DEPTH + 1);
  localparam int unsigned AQ_SUM_W = AQ_CNT_W + 1;

  localparam int unsigned OPQ_DEPTH = 2;
  localparam int unsigned OPQ_PTR_W = $clog2(OPQ_DEPTH);
  localparam int unsigned OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CREDIT      = 2'd3;

  localparam logic [TICK_W-1:0]  RST_ACK_TIMEOUT = 8'd20;
  localparam logic [RETRY_W-1:0] RST_RETRY_LIMIT = 4'd3;
  localparam logic [TICK_W-1:0]  RST_PERIOD      = 8'd11;
  localparam logic [TICK_W-1:0]  RST_CREDIT      = 8'd10;

  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DATA_RX = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ACK_RX  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_P_START = 3'd4;
  localparam logic [CMD_W-1:0] CMD_P_STOP  = 3'd5;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK     = 2'd0,
    KIND_PERSIST = 2'd1,
    KIND_NEW     = 2'd2,
    KIND_RESEND  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ENQ,
    OP_DATA,
    OP_ACK,
    OP_PSTART,
    OP_PSTOP
  } op_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic              slot_open;
    logic [TYPE_W-1:0] msg_type;
    logic [ID_W-1:0]   msg_id;
    logic [ID_W-1:0]   payload_tag;
    logic [CODE_W-1:0] persistent_code;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] frame_kind;
    logic [TYPE_W-1:0] out_type;
    logic [ID_W-1:0]   out_id;
    logic [ID_W-1:0]   out_tag;
    logic [CODE_W-1:0] out_code;
    logic              last;
  } out_item_t;

  typedef struct packed {
    op_e               op;
    logic              slot_open;
    logic [TYPE_W-1:0] msg_type;
    logic [ID_W-1:0]   word;
    logic [CODE_W-1:0] code;
  } op_t;

  typedef struct packed {
    logic [TYPE_W-1:0] msg_type;
    logic [ID_W-1:0]   word;
  } q_entry_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
    return (v == {TICK_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

### src/ssw_if.sv
// Valid/ready channel interfaces for input and result words.
`default_nettype none
interface ssw_in_if import ssw_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ssw_out_if import ssw_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/ssw_front.sv
// Front end: accept input words, decode the command and push operations.
`default_nettype none
module ssw_front import ssw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ssw_in_if.sink    in_i,
  output logic      push_o,
  output op_t       op_o,
  input  wire logic full_i
);

  logic known;

  assign in_i.ready = ~full_i;

  always_comb begin
    known          = 1'b1;
    op_o.op        = OP_TICK;
    op_o.slot_open = in_i.data.slot_open;
    op_o.msg_type  = in_i.data.msg_type;
    op_o.word      = in_i.data.msg_id;
    op_o.code      = in_i.data.persistent_code;
    unique case (in_i.data.command)
      CMD_TICK:    op_o.op = OP_TICK;
      CMD_ENQUEUE: begin
        op_o.op   = OP_ENQ;
        op_o.word = in_i.data.payload_tag;
      end
      CMD_DATA_RX: op_o.op = OP_DATA;
      CMD_ACK_RX:  op_o.op = OP_ACK;
      CMD_P_START: op_o.op = OP_PSTART;
      CMD_P_STOP:  op_o.op = OP_PSTOP;
      default:     known   = 1'b0;
    endcase
  end

  assign push_o = in_i.valid & in_i.ready & known;

  property p_no_push_when_full;
    @(posedge clk_i) disable iff (!rst_ni) full_i |-> !push_o;
  endproperty
  a_no_push_when_full: assert property (p_no_push_when_full)
    else $error("push while operation queue full");

  property p_drop_unknown;
    @(posedge clk_i) disable iff (!rst_ni)
      (in_i.valid && (in_i.data.command != CMD_TICK) && (in_i.data.command != CMD_ENQUEUE)
       && (in_i.data.command != CMD_DATA_RX) && (in_i.data.command != CMD_ACK_RX)
       && (in_i.data.command != CMD_P_START) && (in_i.data.command != CMD_P_STOP))
      |-> !push_o;
  endproperty
  a_drop_unknown: assert property (p_drop_unknown)
    else $error("unused command pushed");

  property p_enq_carries_tag;
    @(posedge clk_i) disable iff (!rst_ni)
      (push_o && (op_o.op == OP_ENQ)) |-> (op_o.word == in_i.data.payload_tag);
  endproperty
  a_enq_carries_tag: assert property (p_enq_carries_tag)
    else $error("enqueue word is not the payload tag");

endmodule
`default_nettype wire

### src/ssw_opq.sv
// Short operation queue between the front end and the back end.
`default_nettype none
module ssw_opq import ssw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  op_i,
  output logic      full_o,
  output logic      valid_o,
  output op_t       op_o,
  input  wire logic pop_i
);

  op_t                  mem_q [OPQ_DEPTH];
  logic [OPQ_PTR_W-1:0] wr_q, rd_q;
  logic [OPQ_CNT_W-1:0] cnt_q;
  logic                 do_pop;

  assign full_o  = (cnt_q == OPQ_CNT_W'(OPQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_q];
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == OPQ_PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  property p_cnt_bound;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= OPQ_CNT_W'(OPQ_DEPTH);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound)
    else $error("operation queue count overflow");

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i;
  endproperty
  a_no_overflow: assert property (p_no_overflow)
    else $error("push into full operation queue");

  property p_pop_valid;
    @(posedge clk_i) disable iff (!rst_ni) (push_i && !do_pop) |=> valid_o;
  endproperty
  a_pop_valid: assert property (p_pop_valid)
    else $error("queue empty after push");

endmodule
`default_nettype wire

### src/ssw_back.sv
// Back end: link state, message and ack queues, tick processing and frame output.
`default_nettype none
module ssw_back import ssw_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_wr_t cfg_i,
  input  wire logic    op_valid_i,
  input  wire op_t     op_i,
  output logic         op_pop_o,
  ssw_out_if.source    out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_EMIT
  } state_e;

  state_e state_q;

  logic [TICK_W-1:0]  cfg_timeout_q, cfg_period_q, cfg_credit_q;
  logic [RETRY_W-1:0] cfg_retry_q;

  q_entry_t sq_mem [SQ_DEPTH];
  q_entry_t aq_mem [AQ_DEPTH];
  q_entry_t sq_rd_q, aq_rd_q;

  logic [SQ_CNT_W-1:0] sq_cnt_q, sq_cnt_d;
  logic [SQ_PTR_W-1:0] sq_head_q, sq_head_d, sq_tail;
  logic [SQ_SUM_W-1:0] sq_sum;
  logic [AQ_CNT_W-1:0] aq_cnt_q, aq_cnt_d;
  logic [AQ_PTR_W-1:0] aq_head_q, aq_head_d, aq_tail;
  logic [AQ_SUM_W-1:0] aq_sum;

  logic               awaiting_q, awaiting_d;
  logic [ID_W-1:0]    pid_q, pid_d;
  logic [TYPE_W-1:0]  ptype_q, ptype_d;
  logic [ID_W-1:0]    ptag_q, ptag_d;
  logic [RETRY_W-1:0] retries_q, retries_d;
  logic [TICK_W-1:0]  tss_q, tss_d;
  logic               p_active_q;
  logic [CODE_W-1:0]  p_code_q;
  logic [TICK_W-1:0]  tsp_q, tsp_d;
  logic [ID_W-1:0]    next_id_q, next_id_d;
  logic               slot_q;

  out_item_t frm0_q, frm1_q, frm0_d, frm1_d, oth;
  logic      oth_valid, ack_valid;
  logic [1:0] frm_n_q, frm_n_d;
  logic      frm_idx_q;

  logic pop;
  logic sq_enq, aq_enq;

  assign op_pop_o = (state_q == S_IDLE);
  assign pop      = op_valid_i & op_pop_o;
  assign sq_enq   = pop && (op_i.op == OP_ENQ) && (sq_cnt_q < SQ_CNT_W'(SQ_DEPTH));
  assign aq_enq   = pop && (op_i.op == OP_DATA) && (aq_cnt_q < AQ_CNT_W'(AQ_DEPTH));

  assign sq_sum  = SQ_SUM_W'(sq_head_q) + SQ_SUM_W'(sq_cnt_q);
  assign sq_tail = (sq_sum >= SQ_SUM_W'(SQ_DEPTH)) ? SQ_PTR_W'(sq_sum - SQ_SUM_W'(SQ_DEPTH))
                                                    : sq_sum[SQ_PTR_W-1:0];
  assign aq_sum  = AQ_SUM_W'(aq_head_q) + AQ_SUM_W'(aq_cnt_q);
  assign aq_tail = (aq_sum >= AQ_SUM_W'(AQ_DEPTH)) ? AQ_PTR_W'(aq_sum - AQ_SUM_W'(AQ_DEPTH))
                                                    : aq_sum[AQ_PTR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (sq_enq) begin
      sq_mem[sq_tail] <= '{msg_type: op_i.msg_type, word: op_i.word};
    end
    if (aq_enq) begin
      aq_mem[aq_tail] <= '{msg_type: op_i.msg_type, word: op_i.word};
    end
    if (pop && (op_i.op == OP_TICK)) begin
      sq_rd_q <= sq_mem[sq_head_q];
      aq_rd_q <= aq_mem[aq_head_q];
    end
  end

  // tick decision, on counters already advanced and head entries already read
  always_comb begin
    aq_head_d  = aq_head_q;
    aq_cnt_d   = aq_cnt_q;
    sq_head_d  = sq_head_q;
    sq_cnt_d   = sq_cnt_q;
    awaiting_d = awaiting_q;
    pid_d      = pid_q;
    ptype_d    = ptype_q;
    ptag_d     = ptag_q;
    retries_d  = retries_q;
    tss_d      = tss_q;
    tsp_d      = tsp_q;
    next_id_d  = next_id_q;
    ack_valid  = 1'b0;
    oth_valid  = 1'b0;
    oth        = '0;
    frm0_d     = '0;
    frm1_d     = '0;

    if (aq_cnt_q != '0) begin
      ack_valid       = 1'b1;
      frm0_d.frame_kind = KIND_ACK;
      frm0_d.out_type = aq_rd_q.msg_type;
      frm0_d.out_id   = aq_rd_q.word;
      aq_head_d = (aq_head_q == AQ_PTR_W'(AQ_DEPTH - 1)) ? '0 : aq_head_q + 1'b1;
      aq_cnt_d  = aq_cnt_q - 1'b1;
    end

    if (p_active_q) begin
      if (tsp_q >= cfg_period_q) begin
        oth_valid      = 1'b1;
        oth.frame_kind = KIND_PERSIST;
        oth.out_code   = p_code_q;
        tsp_d          = '0;
      end
    end else begin
      if (awaiting_q && (tss_q >= cfg_timeout_q)) begin
        if (retries_q < cfg_retry_q) begin
          oth_valid      = 1'b1;
          oth.frame_kind = KIND_RESEND;
          oth.out_type   = ptype_q;
          oth.out_id     = pid_q;
          oth.out_tag    = ptag_q;
          tss_d          = '0;
          retries_d      = retries_q + 1'b1;
        end else begin
          awaiting_d = 1'b0;
          retries_d  = '0;
        end
      end
      if (!awaiting_d && (sq_cnt_q != '0)) begin
        oth_valid      = 1'b1;
        oth.frame_kind = KIND_NEW;
        oth.out_type   = sq_rd_q.msg_type;
        oth.out_id     = next_id_q;
        oth.out_tag    = sq_rd_q.word;
        ptype_d        = sq_rd_q.msg_type;
        ptag_d         = sq_rd_q.word;
        pid_d          = next_id_q;
        next_id_d      = next_id_q + 1'b1;
        awaiting_d     = 1'b1;
        tss_d          = '0;
        retries_d      = '0;
        sq_head_d = (sq_head_q == SQ_PTR_W'(SQ_DEPTH - 1)) ? '0 : sq_head_q + 1'b1;
        sq_cnt_d  = sq_cnt_q - 1'b1;
      end
    end

    oth.last = 1'b1;
    if (ack_valid) begin
      frm0_d.last = ~oth_valid;
      frm1_d      = oth;
    end else begin
      frm0_d = oth;
    end
    frm_n_d = {1'b0, ack_valid} + {1'b0, oth_valid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cfg_timeout_q <= RST_ACK_TIMEOUT;
      cfg_retry_q   <= RST_RETRY_LIMIT;
      cfg_period_q  <= RST_PERIOD;
      cfg_credit_q  <= RST_CREDIT;
      sq_cnt_q      <= '0;
      sq_head_q     <= '0;
      aq_cnt_q      <= '0;
      aq_head_q     <= '0;
      awaiting_q    <= 1'b0;
      pid_q         <= '0;
      ptype_q       <= '0;
      ptag_q        <= '0;
      retries_q     <= '0;
      tss_q         <= '0;
      p_active_q    <= 1'b0;
      p_code_q      <= '0;
      tsp_q         <= '0;
      next_id_q     <= '0;
      slot_q        <= 1'b0;
      frm_n_q       <= '0;
      frm_idx_q     <= 1'b0;
      frm0_q        <= '0;
      frm1_q        <= '0;
    end else begin
      if (cfg_i.we) begin
        unique case (cfg_i.idx)
          CFG_ACK_TIMEOUT: cfg_timeout_q <= cfg_i.data;
          CFG_RETRY_LIMIT: cfg_retry_q   <= cfg_i.data[RETRY_W-1:0];
          CFG_PERIOD:      cfg_period_q  <= cfg_i.data;
          CFG_CREDIT:      cfg_credit_q  <= cfg_i.data;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop) begin
            unique case (op_i.op)
              OP_TICK: begin
                tss_q   <= sat_inc(tss_q);
                tsp_q   <= sat_inc(tsp_q);
                slot_q  <= op_i.slot_open;
                state_q <= S_TICK;
              end
              OP_ENQ: begin
                if (sq_enq) begin
                  sq_cnt_q <= sq_cnt_q + 1'b1;
                end
              end
              OP_DATA: begin
                if (aq_enq) begin
                  aq_cnt_q <= aq_cnt_q + 1'b1;
                end
              end
              OP_ACK: begin
                if (awaiting_q && (pid_q == op_i.word)) begin
                  awaiting_q <= 1'b0;
                  retries_q  <= '0;
                  pid_q      <= '0;
                  ptype_q    <= '0;
                end
              end
              OP_PSTART: begin
                p_active_q <= 1'b1;
                p_code_q   <= op_i.code;
                tsp_q      <= cfg_credit_q;
              end
              OP_PSTOP: p_active_q <= 1'b0;
              default: ;
            endcase
          end
        end
        S_TICK: begin
          state_q <= S_IDLE;
          if (slot_q) begin
            aq_head_q  <= aq_head_d;
            aq_cnt_q   <= aq_cnt_d;
            sq_head_q  <= sq_head_d;
            sq_cnt_q   <= sq_cnt_d;
            awaiting_q <= awaiting_d;
            pid_q      <= pid_d;
            ptype_q    <= ptype_d;
            ptag_q     <= ptag_d;
            retries_q  <= retries_d;
            tss_q      <= tss_d;
            tsp_q      <= tsp_d;
            next_id_q  <= next_id_d;
            frm0_q     <= frm0_d;
            frm1_q     <= frm1_d;
            frm_n_q    <= frm_n_d;
            frm_idx_q  <= 1'b0;
            if (frm_n_d != '0) begin
              state_q <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_o.ready) begin
            if (frm_idx_q || (frm_n_q == 2'd1)) begin
              state_q <= S_IDLE;
            end else begin
              frm_idx_q <= 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid = (state_q == S_EMIT);
  assign out_o.data  = frm_idx_q ? frm1_q : frm0_q;

  property p_sq_bound;
    @(posedge clk_i) disable iff (!rst_ni) sq_cnt_q <= SQ_CNT_W'(SQ_DEPTH);
  endproperty
  a_sq_bound: assert property (p_sq_bound)
    else $error("send queue count overflow");

  property p_aq_bound;
    @(posedge clk_i) disable iff (!rst_ni) aq_cnt_q <= AQ_CNT_W'(AQ_DEPTH);
  endproperty
  a_aq_bound: assert property (p_aq_bound)
    else $error("ack queue count overflow");

  property p_emit_has_frames;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == S_EMIT) |-> (frm_n_q != '0);
  endproperty
  a_emit_has_frames: assert property (p_emit_has_frames)
    else $error("emitting with no frames held");

  property p_data_frame_outstanding;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_o.valid && ((out_o.data.frame_kind == KIND_NEW)
                       || (out_o.data.frame_kind == KIND_RESEND)))
      |-> (awaiting_q && (out_o.data.out_id == pid_q));
  endproperty
  a_data_frame_outstanding: assert property (p_data_frame_outstanding)
    else $error("message frame without matching outstanding message");

endmodule
`default_nettype wire

### src/slotted_stop_and_wait_link.sv
// Top level of the slotted stop-and-wait link, transmit side.
//
// channel   dir  handshake        word
// in_i      in   valid/ready      in_item_t: one event
// out_o     out  valid/ready      out_item_t: one frame, last marks a tick's final
// cfg       in   cfg_we_i         cfg_idx_i selects a register, cfg_data_i holds it
//
// A non-tick event is handled in the back end's idle state; a tick passes
// through head read and decide, then emits each of its up to two frames.
// Two-entry operation queue lets events enter while frames wait to be taken.
// rst_ni clears queues, timers and the outstanding message; registers take
// their defaults. A stalled output holds the back end; the front end stalls
// only once the operation queue is full.
`default_nettype none
module slotted_stop_and_wait_link import ssw_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ssw_in_if.sink                     in_i,
  ssw_out_if.source                  out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic    push, full, op_valid, op_pop;
  op_t     push_op, head_op;
  cfg_wr_t cfg;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  ssw_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .op_o   (push_op),
    .full_i (full)
  );

  ssw_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (full),
    .valid_o (op_valid),
    .op_o    (head_op),
    .pop_i   (op_pop)
  );

  ssw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .op_valid_i (op_valid),
    .op_i       (head_op),
    .op_pop_o   (op_pop),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench: directed and random events vs. a cycle-free link predictor.
module testbench;
  import ssw_pkg::*;

  localparam int unsigned HALF_PERIOD    = 4;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned PHASE_EVENTS   = 155;
  localparam int unsigned LONG_HOLD_AT   = 200;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned TICK_SPAN_MAX  = 20;

  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    in_item_t word;
    logic     ack_live;
  } stim_t;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  ev_valid = 1'b0;
  in_item_t              ev_word  = '0;
  logic                  take_rdy = 1'b0;

  ssw_in_if  ev_if ();
  ssw_out_if frame_if ();

  assign ev_if.valid    = ev_valid;
  assign ev_if.data     = ev_word;
  assign frame_if.ready = take_rdy;

  slotted_stop_and_wait_link i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (ev_if),
    .out_o      (frame_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // link predictor state
  q_entry_t           tx_fifo [SQ_DEPTH];
  int unsigned        tx_count      = 0;
  int unsigned        tx_head       = 0;
  q_entry_t           ack_fifo [AQ_DEPTH];
  int unsigned        ack_count     = 0;
  int unsigned        ack_head      = 0;
  logic               awaiting      = 1'b0;
  logic [ID_W-1:0]    pend_id       = '0;
  logic [TYPE_W-1:0]  pend_type     = '0;
  logic [ID_W-1:0]    pend_tag      = '0;
  logic [RETRY_W-1:0] retries       = '0;
  logic [TICK_W-1:0]  since_send    = '0;
  logic               persist_on    = 1'b0;
  logic [CODE_W-1:0]  persist_code  = '0;
  logic [TICK_W-1:0]  since_persist = '0;
  logic [ID_W-1:0]    next_msg_id   = '0;

  logic [TICK_W-1:0]  lim_timeout  = RST_ACK_TIMEOUT;
  logic [RETRY_W-1:0] lim_retries  = RST_RETRY_LIMIT;
  logic [TICK_W-1:0]  lim_period   = RST_PERIOD;
  logic [TICK_W-1:0]  start_credit = RST_CREDIT;

  out_item_t   frames_due [$];
  stim_t       stim_q [$];
  int unsigned events_taken   = 0;
  int unsigned frames_checked = 0;
  int unsigned settings_run   = 0;
  int unsigned faults         = 0;
  int unsigned ev_gap         = 0;
  int unsigned rx_stall       = 0;
  int unsigned quiet          = 0;
  logic        tx_steady      = 1'b0;
  logic        rx_steady      = 1'b0;

  function automatic out_item_t pack_frame(input kind_e kind, input logic [TYPE_W-1:0] mtype,
                                           input logic [ID_W-1:0] id,
                                           input logic [ID_W-1:0] tag,
                                           input logic [CODE_W-1:0] code);
    out_item_t fr;
    fr = '{frame_kind: kind, out_type: mtype, out_id: id, out_tag: tag, out_code: code,
           last: 1'b0};
    return fr;
  endfunction

  task automatic advance_link(input in_item_t ev);
    out_item_t burst [$];
    out_item_t fr;
    q_entry_t  e;
    case (ev.command)
      CMD_TICK: begin
        if (since_send != '1) since_send++;
        if (since_persist != '1) since_persist++;
        if (ev.slot_open) begin
          if (ack_count != 0) begin
            e = ack_fifo[AQ_PTR_W'(ack_head)];
            ack_head = (ack_head + 1) % AQ_DEPTH;
            ack_count--;
            burst.push_back(pack_frame(KIND_ACK, e.msg_type, e.word, '0, '0));
          end
          if (persist_on) begin
            if (since_persist >= lim_period) begin
              burst.push_back(pack_frame(KIND_PERSIST, '0, '0, '0, persist_code));
              since_persist = '0;
            end
          end else begin
            if (awaiting && since_send >= lim_timeout) begin
              if (retries < lim_retries) begin
                burst.push_back(pack_frame(KIND_RESEND, pend_type, pend_id, pend_tag, '0));
                since_send = '0;
                retries++;
              end else begin
                awaiting = 1'b0;
                retries  = '0;
              end
            end
            if (!awaiting && tx_count != 0) begin
              e = tx_fifo[SQ_PTR_W'(tx_head)];
              tx_head = (tx_head + 1) % SQ_DEPTH;
              tx_count--;
              pend_type   = e.msg_type;
              pend_tag    = e.word;
              pend_id     = next_msg_id;
              next_msg_id = next_msg_id + 1'b1;
              awaiting    = 1'b1;
              since_send  = '0;
              retries     = '0;
              burst.push_back(pack_frame(KIND_NEW, pend_type, pend_id, pend_tag, '0));
            end
          end
          foreach (burst[k]) begin
            fr = burst[k];
            fr.last = (k == burst.size() - 1);
            frames_due.push_back(fr);
          end
        end
      end
      CMD_ENQUEUE: begin
        if (tx_count < SQ_DEPTH) begin
          tx_fifo[SQ_PTR_W'((tx_head + tx_count) % SQ_DEPTH)] = '{msg_type: ev.msg_type,
                                                                  word: ev.payload_tag};
          tx_count++;
        end
      end
      CMD_DATA_RX: begin
        if (ack_count < AQ_DEPTH) begin
          ack_fifo[AQ_PTR_W'((ack_head + ack_count) % AQ_DEPTH)] = '{msg_type: ev.msg_type,
                                                                     word: ev.msg_id};
          ack_count++;
        end
      end
      CMD_ACK_RX: begin
        if (awaiting && pend_id == ev.msg_id) begin
          awaiting  = 1'b0;
          retries   = '0;
          pend_id   = '0;
          pend_type = '0;
        end
      end
      CMD_P_START: begin
        persist_on    = 1'b1;
        persist_code  = ev.persistent_code;
        since_persist = start_credit;
      end
      CMD_P_STOP: persist_on = 1'b0;
      default: ;
    endcase
  endtask

  task automatic check_frame(input out_item_t got);
    out_item_t want;
    if (frames_due.size() == 0) begin
      $error("unexpected frame: frame_kind %0d out_id %0h", got.frame_kind, got.out_id);
      faults++;
    end else begin
      want = frames_due.pop_front();
      if (got.frame_kind !== want.frame_kind) begin
        $error("frame_kind: expected %0d, got %0d", want.frame_kind, got.frame_kind);
        faults++;
      end
      if (got.out_type !== want.out_type) begin
        $error("out_type: expected %0h, got %0h", want.out_type, got.out_type);
        faults++;
      end
      if (got.out_id !== want.out_id) begin
        $error("out_id: expected %0h, got %0h", want.out_id, got.out_id);
        faults++;
      end
      if (got.out_tag !== want.out_tag) begin
        $error("out_tag: expected %0h, got %0h", want.out_tag, got.out_tag);
        faults++;
      end
      if (got.out_code !== want.out_code) begin
        $error("out_code: expected %0h, got %0h", want.out_code, got.out_code);
        faults++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        faults++;
      end
    end
  endtask

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // event driver
  always @(posedge clk) begin : drive_events
    stim_t pick;
    if (rst_n && !(ev_valid && !ev_if.ready)) begin
      if (ev_valid) begin
        advance_link(ev_word);
        events_taken++;
      end
      if (ev_gap != 0) begin
        ev_valid <= 1'b0;
        ev_gap--;
      end else if (stim_q.size() != 0) begin
        pick = stim_q.pop_front();
        if (pick.ack_live) pick.word.msg_id = pend_id;
        ev_word  <= pick.word;
        ev_valid <= 1'b1;
        ev_gap = tx_steady ? 0 : idle_span();
        if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
      end else begin
        ev_valid <= 1'b0;
      end
    end
  end

  // frame monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (frame_if.valid && frame_if.ready) begin
        check_frame(frame_if.data);
        frames_checked++;
        if (frames_checked == LONG_HOLD_AT) rx_stall = LONG_HOLD;
      end
      if (rx_stall != 0) begin
        take_rdy <= 1'b0;
        rx_stall--;
      end else begin
        take_rdy <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) rx_stall = idle_span();
        if ($urandom_range(0, 99) == 0) rx_steady = !rx_steady;
      end
    end
  end

  always @(posedge clk) begin
    if ((ev_if.valid && ev_if.ready) || (frame_if.valid && frame_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic in_item_t ev(input logic [CMD_W-1:0] cmd, input logic slot,
                                  input logic [TYPE_W-1:0] mtype, input logic [ID_W-1:0] mid,
                                  input logic [ID_W-1:0] tag, input logic [CODE_W-1:0] code);
    in_item_t w;
    w = '{command: cmd, slot_open: slot, msg_type: mtype, msg_id: mid, payload_tag: tag,
          persistent_code: code};
    return w;
  endfunction

  function automatic in_item_t any_ev(input logic [CMD_W-1:0] cmd);
    return ev(cmd, 1'($urandom_range(0, 1)), TYPE_W'($urandom), ID_W'($urandom),
              ID_W'($urandom), CODE_W'($urandom));
  endfunction

  task automatic post(input in_item_t w, input logic live);
    stim_q.push_back('{word: w, ack_live: live});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
  endtask

  task automatic set_regs(input logic [TICK_W-1:0] timeout, input logic [RETRY_W-1:0] cap,
                          input logic [TICK_W-1:0] period, input logic [TICK_W-1:0] credit);
    lim_timeout  = timeout;
    lim_retries  = cap;
    lim_period   = period;
    start_credit = credit;
    write_reg(CFG_ACK_TIMEOUT, timeout);
    write_reg(CFG_RETRY_LIMIT, CFG_DATA_W'(cap));
    write_reg(CFG_PERIOD, period);
    write_reg(CFG_CREDIT, credit);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  task automatic settle();
    do @(negedge clk); while (stim_q.size() != 0 || ev_valid || frames_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_directed();
    post(ev(CMD_TICK, 1'b0, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b0);
    post(ev(CMD_TICK, 1'b1, 4'h0, 16'h0000, 16'h0000, 8'h00), 1'b0);
    post(ev(CMD_DATA_RX, 1'b0, 4'hF, 16'hFFFF, 16'h0000, 8'h00), 1'b0);
    post(ev(CMD_DATA_RX, 1'b1, 4'h0, 16'h0000, 16'hFFFF, 8'hFF), 1'b0);
    post(ev(CMD_ENQUEUE, 1'b0, 4'hF, 16'h0000, 16'hFFFF, 8'h00), 1'b0);
    post(ev(CMD_ENQUEUE, 1'b1, 4'h0, 16'hFFFF, 16'h0000, 8'hFF), 1'b0);
    // ack and new, ack and resend, then abandon and start the next message
    repeat (3) post(ev(CMD_TICK, 1'b1, 4'h0, 16'h0000, 16'h0000, 8'h00), 1'b0);
    post(ev(CMD_ACK_RX, 1'b0, 4'h0, 16'h0000, 16'h0000, 8'h00), 1'b1);
    post(ev(CMD_ACK_RX, 1'b0, 4'h0, 16'h5A5A, 16'h0000, 8'h00), 1'b0);
    post(ev(CMD_ENQUEUE, 1'b0, 4'hA, 16'h0000, 16'h1234, 8'h00), 1'b0);
    post(ev(CMD_TICK, 1'b1, 4'h0, 16'h0000, 16'h0000, 8'h00), 1'b0);
    post(ev(CMD_ACK_RX, 1'b0, 4'h0, 16'hFFFF, 16'h0000, 8'h00), 1'b0);
    post(ev(CMD_P_START, 1'b0, 4'h0, 16'h0000, 16'h0000, 8'hFF), 1'b0);
    post(ev(CMD_TICK, 1'b1, 4'h0, 16'h0000, 16'h0000, 8'h00), 1'b0);
    post(ev(CMD_TICK, 1'b0, 4'h0, 16'h0000, 16'h0000, 8'h00), 1'b0);
    post(ev(CMD_TICK, 1'b1, 4'h0, 16'h0000, 16'h0000, 8'h00), 1'b0);
    post(ev(CMD_P_START, 1'b0, 4'h0, 16'h0000, 16'h0000, 8'h00), 1'b0);
    post(ev(CMD_P_STOP, 1'b0, 4'h0, 16'h0000, 16'h0000, 8'h00), 1'b0);
    post(ev(CMD_P_STOP, 1'b0, 4'h0, 16'h0000, 16'h0000, 8'h00), 1'b0);
    post(ev(CMD_SPARE6, 1'b1, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b0);
    post(ev(CMD_SPARE7, 1'b1, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b0);
    post(ev(CMD_TICK, 1'b1, 4'h0, 16'h0000, 16'h0000, 8'h00), 1'b0);
  endtask

  task automatic queue_random(input int unsigned quota);
    int unsigned made;
    int unsigned span;
    int unsigned r;
    in_item_t    w;
    made = 0;
    while (made < quota) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        repeat ($urandom_range(1, 3)) begin
          post(any_ev(CMD_ENQUEUE), 1'b0);
          made++;
        end
        span = lim_timeout * (lim_retries + 1) + 2;
        if (span > TICK_SPAN_MAX) span = TICK_SPAN_MAX;
        repeat ($urandom_range(1, span)) begin
          w = any_ev(CMD_TICK);
          w.slot_open = ($urandom_range(0, 4) != 0);
          post(w, 1'b0);
          made++;
          if ($urandom_range(0, 3) == 0) begin
            post(any_ev(CMD_DATA_RX), 1'b0);
            made++;
          end
        end
        post(any_ev(CMD_ACK_RX), $urandom_range(0, 3) != 0);
        made++;
      end else if (r < 9) begin
        post(any_ev(CMD_P_START), 1'b0);
        made++;
        repeat ($urandom_range(1, 12)) begin
          w = any_ev(CMD_TICK);
          w.slot_open = ($urandom_range(0, 4) != 0);
          post(w, 1'b0);
          made++;
          if ($urandom_range(0, 3) == 0) begin
            post(any_ev(CMD_DATA_RX), 1'b0);
            made++;
          end
        end
        if ($urandom_range(0, 4) != 0) begin
          post(any_ev(CMD_P_STOP), 1'b0);
          made++;
        end
      end else if ($urandom_range(0, 1) == 0) begin
        post(any_ev(CMD_W'($urandom_range(0, 7))), 1'b0);
        made++;
      end else begin
        w = any_ev($urandom_range(0, 1) ? CMD_ENQUEUE : CMD_DATA_RX);
        repeat ($urandom_range(6, 10)) begin
          post(any_ev(w.command), 1'b0);
          made++;
        end
      end
    end
  endtask

  task automatic run_phase(input logic [TICK_W-1:0] timeout, input logic [RETRY_W-1:0] cap,
                           input logic [TICK_W-1:0] period, input logic [TICK_W-1:0] credit);
    settle();
    set_regs(timeout, cap, period, credit);
    queue_random(PHASE_EVENTS);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    set_regs(8'd1, 4'd1, 8'd2, 8'd0);
    queue_directed();
    run_phase(RST_ACK_TIMEOUT, RST_RETRY_LIMIT, RST_PERIOD, RST_CREDIT);
    run_phase(8'd1, 4'd0, 8'd1, 8'd0);
    run_phase(8'd255, 4'd15, 8'd255, 8'd255);
    run_phase(8'd0, 4'd15, 8'd0, 8'd255);
    repeat (3) begin
      run_phase(TICK_W'($urandom_range(1, 8)), RETRY_W'($urandom_range(0, 15)),
                TICK_W'($urandom_range(1, 8)), TICK_W'($urandom_range(0, 255)));
    end
    settle();
    $display("Run covered %0d events and %0d frames over %0d register settings,",
             events_taken, frames_checked, settings_run);
    $display("with random idling on both channels and one long receiver hold.");
    if (faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
